// ===== src/wcm_pkg.sv =====
package wcm_pkg;

    typedef struct packed {
        logic        command;
        logic [11:0] column_x;
        logic        side;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] distance;
        logic [15:0] wall_height;
        logic [11:0] wall_start;
        logic [11:0] wall_end;
        logic [11:0] start_row;
    } wcm_in_t;

    typedef struct packed {
        logic [24:0] pixel_index;
        logic [1:0]  texture_select;
        logic [11:0] texel_index;
        logic        in_window;
        logic        last;
    } wcm_out_t;

    typedef struct packed {
        logic busy;
        logic active;
        logic pop;
    } wcm_status_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FRAME_PITCH   = 2'd2;

endpackage

// ===== src/wcm_front.sv =====
module wcm_front
    import wcm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  wcm_in_t s_data,
    output logic    q_valid,
    output wcm_in_t q_data,
    input  logic    q_pop
);

    wcm_in_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign s_ready = count_reg != 2'd2;
    assign push    = s_valid && s_ready;
    assign q_valid = count_reg != 2'd0;
    assign q_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ===== src/wcm_back.sv =====
module wcm_back
    import wcm_pkg::*;
#(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  wcm_in_t     q_data,
    output logic        q_pop,
    input  logic [12:0] window_width,
    input  logic [12:0] window_height,
    input  logic [13:0] frame_pitch,
    output logic        m_valid,
    input  logic        m_ready,
    output wcm_out_t    m_data,
    output wcm_status_t status
);

    localparam int TWB = $clog2(TEX_WIDTH);
    localparam int THB = $clog2(TEX_HEIGHT);
    localparam int DW  = THB + 17;
    localparam int CW  = $clog2(DW + 1);
    localparam logic [DW-1:0] DIVIDEND = DW'(TEX_HEIGHT) << 16;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_POS  = 2'd3;

    logic [1:0]  state_reg;
    logic        side_reg, dy_neg_reg, dx_pos_reg;
    logic [15:0] pos_frac_reg;
    logic [31:0] dist_reg;
    logic signed [15:0] dsel_reg;
    logic [15:0] height_reg;
    logic [11:0] wstart_reg;
    logic [11:0] wend_reg;
    logic [11:0] srow_reg;
    logic [29:0] prod_reg;
    logic [16:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;

    logic [31:0] step_reg;
    logic [47:0] tpos_reg;
    logic [12:0] crow_reg;
    logic [11:0] erow_reg;
    logic [11:0] ccol_reg;
    logic [11:0] tcol_reg;
    logic [1:0]  sel_reg;
    logic        active_reg;

    logic        m_valid_reg;
    wcm_out_t    m_data_reg;

    logic        out_free;
    logic        do_step;
    logic        do_start;
    logic        do_drop;

    logic signed [48:0] prod_full;
    logic [15:0]        frac;
    logic [TWB-1:0]     tx;
    logic               mirror;
    logic [16:0]        trial;
    logic               ge;
    logic signed [17:0] offset;
    logic signed [50:0] pos_full;
    logic [THB-1:0]     trow;
    logic [THB+TWB-1:0] texel_full;
    logic [26:0]        pix_full;
    logic               is_last;

    assign out_free = !m_valid_reg || m_ready;
    assign do_start = state_reg == S_IDLE && q_valid && q_data.command == CMD_START;
    assign do_drop  = state_reg == S_IDLE && q_valid && q_data.command == CMD_STEP
                      && !active_reg;
    assign do_step  = state_reg == S_IDLE && q_valid && q_data.command == CMD_STEP
                      && active_reg && out_free;
    assign q_pop    = do_start || do_drop || do_step;

    assign prod_full = $signed({1'b0, dist_reg}) * dsel_reg;
    assign frac      = pos_frac_reg + prod_reg[29:14];
    assign mirror    = (!side_reg && dx_pos_reg) || (side_reg && dy_neg_reg);
    assign tx        = mirror ? ~frac[15 -: TWB] : frac[15 -: TWB];

    assign trial = {rem_reg[15:0], quo_reg[DW-1]};
    assign ge    = trial >= {1'b0, height_reg};

    assign offset   = $signed({6'b0, wstart_reg}) - $signed({6'b0, window_height[12:1]})
                      + $signed({3'b0, height_reg[15:1]});
    assign pos_full = offset * $signed({1'b0, step_reg});

    assign trow       = tpos_reg[16 +: THB];
    assign texel_full = {trow, tcol_reg[TWB-1:0]};
    assign pix_full   = crow_reg * frame_pitch + {15'b0, ccol_reg};
    assign is_last    = crow_reg == {1'b0, erow_reg};

    always_ff @(posedge aclk) begin
        if (do_start) begin
            side_reg     <= q_data.side;
            dy_neg_reg   <= q_data.dir_y[15];
            dx_pos_reg   <= !q_data.dir_x[15] && q_data.dir_x != 16'sd0;
            pos_frac_reg <= q_data.side ? q_data.pos_x[15:0] : q_data.pos_y[15:0];
            dist_reg     <= q_data.distance;
            dsel_reg     <= q_data.side ? q_data.dir_x : q_data.dir_y;
            height_reg   <= q_data.wall_height == 16'd0 ? 16'd1 : q_data.wall_height;
            wstart_reg   <= q_data.wall_start;
            wend_reg     <= q_data.wall_end;
            srow_reg     <= q_data.start_row;
            ccol_reg     <= q_data.column_x;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= prod_full[29:0];
            rem_reg  <= 17'd0;
            quo_reg  <= DIVIDEND;
            cnt_reg  <= CW'(DW);
        end
        if (state_reg == S_DIV) begin
            if (cnt_reg == CW'(DW)) begin
                tcol_reg <= 12'(tx);
            end
            rem_reg  <= ge ? trial - {1'b0, height_reg} : trial;
            quo_reg  <= {quo_reg[DW-2:0], ge};
            cnt_reg  <= cnt_reg - 1'b1;
            step_reg <= 32'({quo_reg[DW-2:0], ge});
        end
        if (state_reg == S_POS) begin
            tpos_reg <= pos_full[47:0];
            crow_reg <= {1'b0, srow_reg};
            erow_reg <= wend_reg;
        end
        if (do_step) begin
            m_data_reg.pixel_index    <= pix_full[24:0];
            m_data_reg.texture_select <= sel_reg;
            m_data_reg.texel_index    <= 12'(texel_full);
            m_data_reg.in_window      <= crow_reg < window_height
                                         && {1'b0, ccol_reg} < window_width;
            m_data_reg.last           <= is_last;
            tpos_reg                  <= tpos_reg + {16'b0, step_reg};
            crow_reg                  <= crow_reg + 13'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= 1'b0;
            sel_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (do_start) begin
                        active_reg <= 1'b0;
                        state_reg  <= S_MUL;
                        if (q_data.side) begin
                            sel_reg <= q_data.dir_y[15] ? 2'd2 : 2'd3;
                        end else begin
                            sel_reg <= q_data.dir_x[15] ? 2'd0 : 2'd1;
                        end
                    end
                    if (do_step && (is_last || crow_reg > {1'b0, erow_reg})) begin
                        active_reg <= 1'b0;
                    end
                end
                S_MUL: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= S_POS;
                    end
                end
                S_POS: begin
                    active_reg <= srow_reg <= wend_reg;
                    state_reg  <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (do_step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign status.busy   = state_reg != S_IDLE;
    assign status.active = active_reg;
    assign status.pop    = q_pop;

endmodule

// ===== src/wall_column_texture_mapper.sv =====
// Channel   Ports                          Payload
// input     s_valid / s_ready              s_data (wcm_in_t)
// result    m_valid / m_ready              m_data (wcm_out_t)
// config    cfg_valid / cfg_ready          cfg_index, cfg_data
//
// A row step transaction leaves the queue and its result is registered on the output in the cycle after.
// A column start passes through the back end's multiply, bit-serial divide (for the vertical
// step) and position states before the back end pops the next item from the queue.
// Synchronous active-low reset clears control state; config resets to 640/480/640.
// A stalled result output holds row steps in the queue; starts still proceed.
module wall_column_texture_mapper
    import wcm_pkg::*;
#(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  wcm_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output wcm_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    logic [12:0] window_width_reg;
    logic [12:0] window_height_reg;
    logic [13:0] frame_pitch_reg;
    logic        q_valid;
    logic        q_pop;
    wcm_in_t     q_data;
    wcm_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_width_reg  <= 13'd640;
            window_height_reg <= 13'd480;
            frame_pitch_reg   <= 14'd640;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[12:0];
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_data[12:0];
                REG_FRAME_PITCH:   frame_pitch_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    wcm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    wcm_back #(
        .TEX_WIDTH  (TEX_WIDTH),
        .TEX_HEIGHT (TEX_HEIGHT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .window_width  (window_width_reg),
        .window_height (window_height_reg),
        .frame_pitch   (frame_pitch_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .status        (status)
    );

    a_full_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid) else $error("queue full but empty");

    a_no_pop_in_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> !status.pop) else $error("pop during column setup");

    a_result_needs_column: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(status.active)) else $error("result without column");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import wcm_pkg::*;

    localparam int TEXW = 64;
    localparam int TEXH = 64;
    localparam int DRAIN = 64;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    wcm_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    wcm_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [13:0] cfg_data = '0;

    wall_column_texture_mapper #(.TEX_WIDTH(TEXW), .TEX_HEIGHT(TEXH)) uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mapper model state
    logic [12:0] win_w, win_h;
    logic [13:0] pitch;
    logic [47:0] tex_pos;
    logic [31:0] v_step;
    logic [12:0] cur_row;
    logic [11:0] last_row, cur_col, tex_col;
    logic [1:0]  tex_sel;
    logic        col_busy;

    wcm_out_t pixel_q[$];
    int       mismatches = 0;
    int       n_accepted = 0;

    task automatic mapper_predict(input wcm_in_t it, output bit produced, output wcm_out_t r);
        logic [63:0] dx, dy, prod, frac, tx, h, ofs, row;
        logic [5:0]  trow;
        bit          is_last;
        produced = 0;
        r = '0;
        if (it.command == CMD_START) begin
            dx = 64'(it.dir_x);
            dy = 64'(it.dir_y);
            if (it.side == 1'b0) tex_sel = it.dir_x < 0 ? 2'd0 : 2'd1;
            else tex_sel = it.dir_y < 0 ? 2'd2 : 2'd3;
            prod = 64'(it.distance) * (it.side == 1'b0 ? dy : dx);
            frac = (64'(it.side == 1'b0 ? it.pos_y : it.pos_x) + (prod >> 14)) & 64'hFFFF;
            tx = (frac * TEXW) >> 16;
            if ((it.side == 1'b0 && it.dir_x > 0) || (it.side == 1'b1 && it.dir_y < 0))
                tx = TEXW - tx - 1;
            tex_col = tx[11:0];
            h = (it.wall_height == 0) ? 64'd1 : 64'(it.wall_height);
            v_step = 32'((64'(TEXH) << 16) / h);
            ofs = 64'(it.wall_start) - 64'(win_h >> 1) + (h >> 1);
            tex_pos = 48'(ofs * 64'(v_step));
            cur_col = it.column_x;
            cur_row = 13'(it.start_row);
            last_row = it.wall_end;
            col_busy = it.start_row <= it.wall_end;
        end else if (col_busy) begin
            row = 64'(cur_row);
            trow = tex_pos[21:16];
            tex_pos = tex_pos + 48'(v_step);
            is_last = row == 64'(last_row);
            r.pixel_index = 25'(row * pitch + cur_col);
            r.texture_select = tex_sel;
            r.texel_index = 12'(64'(trow) * TEXW + tex_col);
            r.in_window = (row < win_h) && (cur_col < win_w);
            r.last = is_last;
            cur_row = cur_row + 13'd1;
            if (is_last || row > last_row) col_busy = 0;
            produced = 1;
        end
    endtask

    // result check
    always @(posedge aclk) begin
        wcm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", m_data);
            end else begin
                want = pixel_q.pop_front();
                if (m_data.pixel_index !== want.pixel_index ||
                    m_data.texture_select !== want.texture_select ||
                    m_data.texel_index !== want.texel_index ||
                    m_data.in_window !== want.in_window ||
                    m_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pix %0d sel %0d texel %0d win %b last %b / got pix %0d sel %0d texel %0d win %b last %b",
                            want.pixel_index, want.texture_select, want.texel_index,
                            want.in_window, want.last, m_data.pixel_index,
                            m_data.texture_select, m_data.texel_index, m_data.in_window,
                            m_data.last);
                end
            end
        end
    end

    // receiver: rotating stall patterns plus one long hold-off
    initial begin
        int cyc, mode;
        bit held;
        cyc = 0;
        mode = 0;
        held = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (!held && n_accepted >= 400) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (500) @(posedge aclk);
            end
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= (cyc % 3) != 0;
                2: m_ready <= $urandom_range(0, 3) != 0;
                default: m_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    // sender
    int burst_left = 0;

    task automatic push_item(input wcm_in_t it, input bit typed, input wcm_out_t typed_r);
        bit       got;
        wcm_out_t r;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        n_accepted++;
        mapper_predict(it, got, r);
        if (got) pixel_q.push_back(typed ? typed_r : r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WINDOW_WIDTH:  win_w = 13'(val);
            REG_WINDOW_HEIGHT: win_h = 13'(val);
            REG_FRAME_PITCH:   pitch = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic wcm_in_t start_item(input int col, input bit sd, input int dx, input int dy,
                                           input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] wall_dst, input int h,
                                           input int ws, input int we, input int sr);
        wcm_in_t it;
        it.command = CMD_START;
        it.column_x = 12'(col);
        it.side = sd;
        it.dir_x = 16'(dx);
        it.dir_y = 16'(dy);
        it.pos_x = px;
        it.pos_y = py;
        it.distance = wall_dst;
        it.wall_height = 16'(h);
        it.wall_start = 12'(ws);
        it.wall_end = 12'(we);
        it.start_row = 12'(sr);
        return it;
    endfunction

    function automatic wcm_in_t junk_item();
        wcm_in_t      it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(wcm_in_t)-1:0];
        return it;
    endfunction

    function automatic wcm_in_t step_item();
        wcm_in_t it;
        it = junk_item();
        it.command = CMD_STEP;
        return it;
    endfunction

    function automatic wcm_in_t rand_start();
        wcm_in_t it;
        int sr, len;
        it = junk_item();
        it.command = CMD_START;
        case ($urandom_range(0, 3))
            0: it.wall_height = 16'($urandom_range(0, 4));
            1: it.wall_height = 16'hFFFF - 16'($urandom_range(0, 3));
            default: it.wall_height = 16'($urandom_range(1, 600));
        endcase
        sr = $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0) sr = $urandom_range(0, 700);
        len = $urandom_range(0, 12);
        it.start_row = 12'(sr);
        if ($urandom_range(0, 9) == 0) it.wall_end = 12'($urandom_range(0, 4095));
        else it.wall_end = 12'((sr + len > 4095) ? 4095 : sr + len);
        return it;
    endfunction

    wcm_in_t  dir_rows[$];
    bit       dir_typed[$];
    wcm_out_t dir_res[$];

    task automatic add_row(input wcm_in_t it, input bit typed, input wcm_out_t r);
        dir_rows.push_back(it);
        dir_typed.push_back(typed);
        dir_res.push_back(r);
    endtask

    task automatic random_items(input int count);
        wcm_in_t it;
        int k, n;
        k = 0;
        while (k < count) begin
            if ($urandom_range(0, 9) == 0) begin
                it = junk_item();
                push_item(it, 0, '0);
                k++;
            end else begin
                it = rand_start();
                push_item(it, 0, '0);
                k++;
                n = (it.wall_end >= it.start_row) ? it.wall_end - it.start_row + 1 : 1;
                if (n > 14) n = $urandom_range(1, 14);
                n = n + $urandom_range(0, 2);
                if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
                repeat (n) begin
                    push_item(step_item(), 0, '0);
                    k++;
                end
            end
        end
    endtask

    initial begin
        wcm_out_t r;
        win_w = 13'd640;
        win_h = 13'd480;
        pitch = 14'd640;
        tex_pos = '0;
        v_step = '0;
        cur_row = '0;
        last_row = '0;
        cur_col = '0;
        tex_col = '0;
        tex_sel = '0;
        col_busy = 0;

        // plain column under reset settings: position starts at zero
        add_row(start_item(0, 0, 0, 0, 0, 0, 0, 64, 208, 1, 0), 0, '0);
        r = '{pixel_index: 0, texture_select: 1, texel_index: 0, in_window: 1, last: 0};
        add_row(step_item(), 1, r);
        r = '{pixel_index: 640, texture_select: 1, texel_index: 64, in_window: 1, last: 1};
        add_row(step_item(), 1, r);
        add_row(step_item(), 0, '0);
        // extremes
        add_row(start_item(4095, 1, -32768, -32768, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           65535, 4095, 4095, 4095), 0, '0);
        add_row(step_item(), 0, '0);
        add_row(start_item(639, 0, 32767, 32767, 32'h0001_8000, 32'h0002_4000, 32'h0003_0000,
                           0, 0, 5, 3), 0, '0);
        add_row(step_item(), 0, '0);
        add_row(start_item(100, 1, 32767, -1, 32'h00FF_FFFF, 0, 32'h7FFF_FFFF,
                           1, 4095, 2, 0), 0, '0);
        add_row(step_item(), 0, '0);
        add_row(start_item(10, 0, -1, 100, 1, 2, 3, 300, 90, 478, 476), 0, '0);
        add_row(step_item(), 0, '0);
        add_row(step_item(), 0, '0);
        add_row(step_item(), 0, '0);
        add_row(step_item(), 0, '0);
        // empty slice, then a step with nothing active
        add_row(start_item(5, 1, 0, 0, 0, 0, 0, 20, 0, 3, 4), 0, '0);
        add_row(step_item(), 0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) push_item(dir_rows[i], dir_typed[i], dir_res[i]);
        wait_idle();
        random_items(300);
        wait_idle();

        write_reg(REG_WINDOW_WIDTH, 14'd1);
        write_reg(REG_WINDOW_HEIGHT, 14'd1);
        write_reg(REG_FRAME_PITCH, 14'd1);
        random_items(150);
        wait_idle();

        write_reg(REG_WINDOW_WIDTH, 14'd4096);
        write_reg(REG_WINDOW_HEIGHT, 14'd4096);
        write_reg(REG_FRAME_PITCH, 14'd8192);
        random_items(150);
        wait_idle();

        write_reg(REG_WINDOW_WIDTH, 14'h3FFF);
        write_reg(REG_WINDOW_HEIGHT, 14'h3FFF);
        write_reg(REG_FRAME_PITCH, 14'h3FFF);
        write_reg(2'd3, 14'($urandom));
        random_items(150);
        wait_idle();

        write_reg(REG_WINDOW_WIDTH, 14'($urandom_range(1, 4096)));
        write_reg(REG_WINDOW_HEIGHT, 14'($urandom_range(1, 4096)));
        write_reg(REG_FRAME_PITCH, 14'($urandom_range(1, 8192)));
        random_items(280);
        wait_idle();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
